### design/ctls_pkg.sv
// Shared types and constants of the command text line splitter.
package ctls_pkg;

  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_POP    = 3'd2,
    MODE_READ   = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_EMPTY    = 2'd2
  } status_e;

  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_RETURN    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;

  // Scan flags carried from one byte to the next.
  typedef struct packed {
    logic quoted;
    logic comment;
    logic skip;
  } scan_flags_t;

  // Verdict of the scanner for one byte.
  typedef struct packed {
    scan_flags_t flags;
    logic        start_comment;
    logic        stop;
  } scan_res_t;

endpackage

### design/ctls_if.sv
// Valid/ready channel interfaces for input items and result items.
interface ctls_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [7:0]  text_byte;
  logic [12:0] text_length;
  logic [12:0] requested_length;
  logic        first_of_text;
  logic [9:0]  line_index;

  modport source (output valid, mode, text_byte, text_length, requested_length,
                  first_of_text, line_index, input ready);
  modport sink (input valid, mode, text_byte, text_length, requested_length,
                first_of_text, line_index, output ready);
endinterface

interface ctls_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        got_line;
  logic        line_overflow;
  logic [9:0]  line_length;
  logic [7:0]  line_byte;
  logic [12:0] buffer_size;
  logic        buffer_empty;

  modport source (output valid, status, got_line, line_overflow, line_length, line_byte,
                  buffer_size, buffer_empty, input ready);
  modport sink (input valid, status, got_line, line_overflow, line_length, line_byte,
                buffer_size, buffer_empty, output ready);
endinterface

### design/ctls_scan_step.sv
// Per-byte classifier of the line scan: quotes, escapes, comments and terminators.
module ctls_scan_step (
  input  logic                   at_start_i,
  input  logic                   has_next_i,
  input  logic [7:0]             cur_i,
  input  logic [7:0]             nxt_i,
  input  logic [7:0]             prev_i,
  input  ctls_pkg::scan_flags_t  flags_i,
  output ctls_pkg::scan_res_t    res_o
);

  logic quoted;

  always_comb begin
    quoted = flags_i.quoted;
    res_o  = '0;
    res_o.flags.quoted  = flags_i.quoted;
    res_o.flags.comment = flags_i.comment;
    if (flags_i.skip) begin
      // An escaped quote or backslash is passed over untouched.
      res_o.flags.skip = 1'b0;
    end else begin
      if (!flags_i.comment) begin
        if (cur_i == ctls_pkg::CHAR_QUOTE) begin
          quoted = !quoted;
        end
        res_o.flags.quoted = quoted;
        if (quoted) begin
          if (has_next_i && cur_i == ctls_pkg::CHAR_BACKSLASH &&
              (nxt_i == ctls_pkg::CHAR_QUOTE || nxt_i == ctls_pkg::CHAR_BACKSLASH)) begin
            res_o.flags.skip = 1'b1;
          end
        end else begin
          if (cur_i == ctls_pkg::CHAR_SLASH && has_next_i && nxt_i == ctls_pkg::CHAR_SLASH &&
              (at_start_i || prev_i <= ctls_pkg::CHAR_SPACE)) begin
            res_o.flags.comment = 1'b1;
            res_o.start_comment = 1'b1;
          end
          if (cur_i == ctls_pkg::CHAR_SEMICOLON) begin
            res_o.stop = 1'b1;
          end
        end
      end
      if (cur_i == ctls_pkg::CHAR_NEWLINE || cur_i == ctls_pkg::CHAR_RETURN) begin
        res_o.stop = 1'b1;
      end
    end
  end

endmodule

### design/command_text_line_splitter.sv
// Top level of the command text line splitter: sequencer, text and line memories.
// Every input transfer yields exactly one result transfer. The block holds one item at a
// time and is not ready while it works. All work on the command buffer goes through its
// single read port and single write port, one byte per cycle, so the cost of an item is
// set by how many bytes it must touch there. Append, clear, unused modes and empty pops
// touch at most one byte there, and reading a line byte touches none. An insert at
// position pos moves the bytes above it up one at a time, then writes the new byte at
// pos; when nothing has to move it only writes. A pop scans the line up to and including
// its terminator, one byte at a time, then moves the remaining bytes down to the front,
// again one at a time. A pop that empties the buffer skips the move. A new input
// transfer is taken while the previous result still waits at the output register; a
// result is only launched once that register is free. Neither memory needs clearing
// after reset: only bytes below the fill count and below the stored line length are
// ever read.
module command_text_line_splitter #(
  parameter int BUFFER_BYTES = 4096,
  parameter int LINE_BYTES   = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctls_in_if.sink    in_i,
  ctls_out_if.source out_o
);

  localparam int AW  = $clog2(BUFFER_BYTES);
  localparam int FW  = $clog2(BUFFER_BYTES + 1);
  localparam int LW  = $clog2(LINE_BYTES);
  localparam int CW  = (FW > 13) ? FW + 1 : 14;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_LINE_RD = 7'b0000010,
    ST_LOAD    = 7'b0000100,
    ST_SCAN    = 7'b0001000,
    ST_MOVE    = 7'b0010000,
    ST_PUT     = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Control state.
  logic [FW-1:0] fill_q, fill_d;
  logic [LW-1:0] slen_q, slen_d;
  logic          txt_acc_q, txt_acc_d;
  logic [12:0]   wp_q, wp_d;
  logic          out_valid_q, out_valid_d;

  // Working registers.
  logic [1:0]    status_q, status_d;
  logic          got_q, got_d;
  logic          ovf_q, ovf_d;
  logic [7:0]    lbyte_q, lbyte_d;
  logic [9:0]    idx_q, idx_d;
  logic [7:0]    byte_q, byte_d;
  logic [FW-1:0] pos_q, pos_d;
  logic          ins_q, ins_d;
  logic [FW-1:0] p_q, p_d;
  logic [7:0]    cur_q, cur_d;
  logic [7:0]    prev_q, prev_d;
  logic [FW-1:0] cut_q, cut_d;
  ctls_pkg::scan_flags_t flags_q, flags_d;
  logic [FW-1:0] mv_rd_q, mv_rd_d;
  logic [FW-1:0] mv_wr_q, mv_wr_d;
  logic [FW-1:0] mv_cnt_q, mv_cnt_d;
  logic          mv_pend_q, mv_pend_d;
  logic          mv_up_q, mv_up_d;

  // Result register.
  logic [1:0]    o_status_q;
  logic          o_got_q, o_ovf_q;
  logic [9:0]    o_llen_q;
  logic [7:0]    o_lbyte_q;
  logic [12:0]   o_size_q;
  logic          o_empty_q;
  logic          out_load;

  // Memory ports.
  logic [7:0]    text_mem [BUFFER_BYTES];
  logic [7:0]    line_mem [LINE_BYTES];
  logic [AW-1:0] t_raddr;
  logic [7:0]    t_rdata_q;
  logic          t_we;
  logic [AW-1:0] t_waddr;
  logic [7:0]    t_wdata;
  logic          l_we;
  logic [7:0]    l_rdata_q;

  logic          in_fire;
  logic [CW-1:0] room;
  logic [FW-1:0] ins_pos;
  logic          has_next;
  logic [FW-1:0] split;
  logic [FW-1:0] used;
  ctls_pkg::scan_res_t scan_res;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign room       = CW'(BUFFER_BYTES) - CW'(fill_q);
  assign ins_pos    = (CW'(wp_q) > CW'(fill_q)) ? fill_q : FW'(wp_q);
  assign has_next   = (CW'(p_q) + CW'(1)) < CW'(fill_q);

  ctls_scan_step u_scan (
    .at_start_i (p_q == '0),
    .has_next_i (has_next),
    .cur_i      (cur_q),
    .nxt_i      (t_rdata_q),
    .prev_i     (prev_q),
    .flags_i    (flags_q),
    .res_o      (scan_res)
  );

  assign split = scan_res.stop ? p_q : fill_q;
  assign used  = p_q + FW'(1);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    slen_d      = slen_q;
    txt_acc_d   = txt_acc_q;
    wp_d        = wp_q;
    status_d    = status_q;
    got_d       = got_q;
    ovf_d       = ovf_q;
    lbyte_d     = lbyte_q;
    idx_d       = idx_q;
    byte_d      = byte_q;
    pos_d       = pos_q;
    ins_d       = ins_q;
    p_d         = p_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    cut_d       = cut_q;
    flags_d     = flags_q;
    mv_rd_d     = mv_rd_q;
    mv_wr_d     = mv_wr_q;
    mv_cnt_d    = mv_cnt_q;
    mv_pend_d   = mv_pend_q;
    mv_up_d     = mv_up_q;
    t_raddr     = '0;
    t_we        = 1'b0;
    t_waddr     = AW'(fill_q);
    t_wdata     = in_i.text_byte;
    l_we        = 1'b0;
    out_load    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          status_d = ctls_pkg::STATUS_OK;
          got_d    = 1'b0;
          ovf_d    = 1'b0;
          lbyte_d  = '0;
          idx_d    = in_i.line_index;
          byte_d   = in_i.text_byte;
          state_d  = ST_DONE;
          case (in_i.mode)
            ctls_pkg::MODE_APPEND, ctls_pkg::MODE_INSERT: begin
              ins_d = (in_i.mode == ctls_pkg::MODE_INSERT);
              if (in_i.first_of_text) begin
                txt_acc_d = 1'b0;
                wp_d      = '0;
                if (in_i.text_length != '0) begin
                  if (CW'(in_i.text_length) >= room ||
                      (in_i.mode == ctls_pkg::MODE_INSERT &&
                       CW'(in_i.requested_length) >= room)) begin
                    status_d = ctls_pkg::STATUS_OVERFLOW;
                  end else begin
                    // Room is known to exist, so the first byte always fits.
                    txt_acc_d = 1'b1;
                    if (in_i.mode == ctls_pkg::MODE_INSERT) begin
                      pos_d    = '0;
                      mv_rd_d  = fill_q - FW'(1);
                      mv_wr_d  = fill_q;
                      mv_cnt_d = fill_q;
                      mv_up_d  = 1'b0;
                      mv_pend_d = 1'b0;
                      state_d  = (fill_q == '0) ? ST_PUT : ST_MOVE;
                    end else begin
                      t_we   = 1'b1;
                      fill_d = fill_q + FW'(1);
                      wp_d   = 13'd1;
                    end
                  end
                end
              end else if (txt_acc_q && wp_q < in_i.text_length &&
                           CW'(fill_q) < CW'(BUFFER_BYTES)) begin
                if (in_i.mode == ctls_pkg::MODE_INSERT) begin
                  pos_d     = ins_pos;
                  mv_rd_d   = fill_q - FW'(1);
                  mv_wr_d   = fill_q;
                  mv_cnt_d  = fill_q - ins_pos;
                  mv_up_d   = 1'b0;
                  mv_pend_d = 1'b0;
                  state_d   = (fill_q == ins_pos) ? ST_PUT : ST_MOVE;
                end else begin
                  t_we   = 1'b1;
                  fill_d = fill_q + FW'(1);
                  wp_d   = wp_q + 13'd1;
                end
              end
            end
            ctls_pkg::MODE_POP: begin
              txt_acc_d = 1'b0;
              if (fill_q == '0) begin
                status_d = ctls_pkg::STATUS_EMPTY;
              end else begin
                got_d   = 1'b1;
                t_raddr = '0;
                state_d = ST_LOAD;
              end
            end
            ctls_pkg::MODE_READ: begin
              state_d = ST_LINE_RD;
            end
            ctls_pkg::MODE_CLEAR: begin
              fill_d    = '0;
              txt_acc_d = 1'b0;
              wp_d      = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_LINE_RD: begin
        if (32'(idx_q) < 32'(slen_q) && 32'(idx_q) < LINE_BYTES) begin
          lbyte_d = l_rdata_q;
        end
        state_d = ST_DONE;
      end

      ST_LOAD: begin
        cur_d   = t_rdata_q;
        prev_d  = '0;
        p_d     = '0;
        flags_d = '0;
        cut_d   = '0;
        t_raddr = AW'(1);
        state_d = ST_SCAN;
      end

      ST_SCAN: begin
        t_raddr = AW'(CW'(p_q) + CW'(2));
        l_we    = (32'(p_q) < LINE_BYTES);
        flags_d = scan_res.flags;
        if (scan_res.start_comment) begin
          cut_d = p_q;
        end
        prev_d = cur_q;
        cur_d  = t_rdata_q;
        p_d    = p_q + FW'(1);
        if (scan_res.stop || !has_next) begin
          if (32'(split) >= LINE_BYTES - 1) begin
            ovf_d  = 1'b1;
            slen_d = '0;
          end else begin
            slen_d = LW'(scan_res.flags.comment ? (scan_res.start_comment ? p_q : cut_q)
                                                : split);
          end
          if (!scan_res.stop) begin
            fill_d  = '0;
            state_d = ST_DONE;
          end else begin
            fill_d    = fill_q - used;
            mv_rd_d   = used;
            mv_wr_d   = '0;
            mv_cnt_d  = fill_q - used;
            mv_up_d   = 1'b1;
            mv_pend_d = 1'b0;
            ins_d     = 1'b0;
            state_d   = (fill_q == used) ? ST_DONE : ST_MOVE;
          end
        end
      end

      ST_MOVE: begin
        // One byte read and one byte written each cycle, each write in the cycle after its read.
        t_raddr = AW'(mv_rd_q);
        t_waddr = AW'(mv_wr_q);
        t_wdata = t_rdata_q;
        if (mv_pend_q) begin
          t_we    = 1'b1;
          mv_wr_d = mv_up_q ? mv_wr_q + FW'(1) : mv_wr_q - FW'(1);
        end
        if (mv_cnt_q != '0) begin
          mv_rd_d   = mv_up_q ? mv_rd_q + FW'(1) : mv_rd_q - FW'(1);
          mv_cnt_d  = mv_cnt_q - FW'(1);
          mv_pend_d = 1'b1;
        end else begin
          mv_pend_d = 1'b0;
          if (!mv_pend_q) begin
            state_d = ins_q ? ST_PUT : ST_DONE;
          end
        end
      end

      ST_PUT: begin
        t_we    = 1'b1;
        t_waddr = AW'(pos_q);
        t_wdata = byte_q;
        fill_d  = fill_q + FW'(1);
        wp_d    = wp_q + 13'd1;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      slen_q      <= '0;
      txt_acc_q   <= 1'b0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      slen_q      <= slen_d;
      txt_acc_q   <= txt_acc_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    got_q     <= got_d;
    ovf_q     <= ovf_d;
    lbyte_q   <= lbyte_d;
    idx_q     <= idx_d;
    byte_q    <= byte_d;
    pos_q     <= pos_d;
    ins_q     <= ins_d;
    p_q       <= p_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    cut_q     <= cut_d;
    flags_q   <= flags_d;
    mv_rd_q   <= mv_rd_d;
    mv_wr_q   <= mv_wr_d;
    mv_cnt_q  <= mv_cnt_d;
    mv_pend_q <= mv_pend_d;
    mv_up_q   <= mv_up_d;
    if (out_load) begin
      o_status_q <= status_q;
      o_got_q    <= got_q;
      o_ovf_q    <= ovf_q;
      o_llen_q   <= 10'(slen_q);
      o_lbyte_q  <= lbyte_q;
      o_size_q   <= 13'(fill_q);
      o_empty_q  <= (fill_q == '0);
    end
  end

  // Command buffer memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (t_we) begin
      text_mem[t_waddr] <= t_wdata;
    end
    t_rdata_q <= text_mem[t_raddr];
  end

  // Line store: written while scanning, read for line byte requests.
  always_ff @(posedge clk_i) begin
    if (l_we) begin
      line_mem[LW'(p_q)] <= cur_q;
    end
    l_rdata_q <= line_mem[LW'(in_i.line_index)];
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = o_status_q;
  assign out_o.got_line      = o_got_q;
  assign out_o.line_overflow = o_ovf_q;
  assign out_o.line_length   = o_llen_q;
  assign out_o.line_byte     = o_lbyte_q;
  assign out_o.buffer_size   = o_size_q;
  assign out_o.buffer_empty  = o_empty_q;

endmodule
